// File: hw/rtl/rotary_detent_torque_controller_defines.svh
// Assertion macros shared by the detent controller checker.
`ifndef ROTARY_DETENT_TORQUE_CONTROLLER_DEFINES_SVH
`define ROTARY_DETENT_TORQUE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rdtc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rdtc assertion failed");

`endif

// File: hw/rtl/rdtc_pkg.sv
// Types and constants for the rotary detent torque controller.
package rdtc_pkg;

	localparam int unsigned ZONE_W     = 6;
	localparam int unsigned ZCNT_W     = 7;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned TORQUE_W   = 17;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_GAIN = 1'b1;

	// Reset values and limits
	localparam logic [ZCNT_W-1:0] ZONE_COUNT_RST  = 7'd10;
	localparam logic [GAIN_W-1:0] TORQUE_GAIN_RST = 16'd175;
	localparam logic [ZCNT_W-1:0] ZONES_MIN       = 7'd1;
	localparam logic [ZCNT_W-1:0] ZONES_MAX       = 7'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_TORQUE,
		ST_FINISH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take_sample;
		logic do_scale;
		logic do_torque;
		logic load_out;
	} ctl_cmd_t;

endpackage

// File: hw/rtl/rdtc_ctrl.sv
// Controller state machine and result-valid flag for the detent controller.
module rdtc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	output logic                result_valid,
	input  logic                result_stall,
	output rdtc_pkg::ctl_cmd_t  cmd
);

	rdtc_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdtc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			rdtc_pkg::ST_IDLE: begin
				if (sample_valid) begin
					cmd.take_sample = 1'b1;
					state_d         = rdtc_pkg::ST_SCALE;
				end
			end
			rdtc_pkg::ST_SCALE: begin
				cmd.do_scale = 1'b1;
				state_d      = rdtc_pkg::ST_TORQUE;
			end
			rdtc_pkg::ST_TORQUE: begin
				cmd.do_torque = 1'b1;
				state_d       = rdtc_pkg::ST_FINISH;
			end
			rdtc_pkg::ST_FINISH: begin
				// wait until the output register is free or drains this cycle
				if (!out_valid_q || !result_stall) begin
					cmd.load_out = 1'b1;
					state_d      = rdtc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rdtc_pkg::ST_IDLE;
			end
		endcase
	end

	assign sample_stall = (state_q != rdtc_pkg::ST_IDLE);
	assign result_valid = out_valid_q;

endmodule

// File: hw/rtl/rdtc_datapath.sv
// Datapath: position tracking, zone scaling, torque multiply, output register.
module rdtc_datapath #(
	parameter int unsigned ANGLE_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rdtc_pkg::ctl_cmd_t                    cmd,
	input  logic [ANGLE_BITS-1:0]                 encoder_angle,
	input  logic                                  cfg_valid,
	input  logic [rdtc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rdtc_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic signed [rdtc_pkg::TORQUE_W-1:0]  torque_command,
	output logic [rdtc_pkg::ZONE_W-1:0]           zone_index,
	output logic [ANGLE_BITS-1:0]                 tracked_position
);

	localparam int unsigned SC_W = ANGLE_BITS + rdtc_pkg::ZCNT_W;
	localparam int unsigned PR_W = ANGLE_BITS + rdtc_pkg::GAIN_W;
	localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

	logic [rdtc_pkg::ZCNT_W-1:0]  zone_count_q;
	logic [rdtc_pkg::GAIN_W-1:0]  torque_gain_q;
	logic [ANGLE_BITS-1:0]        last_angle_q;
	logic [ANGLE_BITS-1:0]        pos_q;
	logic [rdtc_pkg::ZCNT_W-1:0]  zones_eff;
	logic [SC_W-1:0]              scaled_s1;
	logic [PR_W-1:0]              prod_s2;
	logic                         neg_s2;
	logic [rdtc_pkg::ZONE_W-1:0]  zone_s2;
	logic [ANGLE_BITS-1:0]        resid;
	logic                         above;
	logic [ANGLE_BITS-1:0]        mag;
	logic [rdtc_pkg::GAIN_W-1:0]  quot;
	logic [rdtc_pkg::TORQUE_W-1:0] quot_ext;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_count_q  <= rdtc_pkg::ZONE_COUNT_RST;
			torque_gain_q <= rdtc_pkg::TORQUE_GAIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rdtc_pkg::REG_ZONE_COUNT:  zone_count_q  <= cfg_data[rdtc_pkg::ZCNT_W-1:0];
				rdtc_pkg::REG_TORQUE_GAIN: torque_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp zone count into 1..64
	always_comb begin
		priority if (zone_count_q == '0) begin
			zones_eff = rdtc_pkg::ZONES_MIN;
		end else if (zone_count_q > rdtc_pkg::ZONES_MAX) begin
			zones_eff = rdtc_pkg::ZONES_MAX;
		end else begin
			zones_eff = zone_count_q;
		end
	end

	// Mirrored position tracking, wraps modulo one turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q <= '0;
			pos_q        <= '0;
		end else if (cmd.take_sample) begin
			last_angle_q <= encoder_angle;
			pos_q        <= pos_q + last_angle_q - encoder_angle;
		end
	end

	// Stage 1: position times zone count
	always_ff @(posedge clk) begin
		if (cmd.do_scale) begin
			scaled_s1 <= SC_W'(pos_q) * SC_W'(zones_eff);
		end
	end

	// Offset from zone center: the low bits against half a turn
	assign resid = scaled_s1[ANGLE_BITS-1:0];
	assign above = (resid >= HALF);
	assign mag   = above ? (resid - HALF) : (HALF - resid);

	// Stage 2: offset times gain
	always_ff @(posedge clk) begin
		if (cmd.do_torque) begin
			prod_s2 <= PR_W'(mag) * PR_W'(torque_gain_q);
			neg_s2  <= !above;
			zone_s2 <= scaled_s1[ANGLE_BITS +: rdtc_pkg::ZONE_W];
		end
	end

	// Divide by half a turn is a shift; result never exceeds the gain
	assign quot     = prod_s2[ANGLE_BITS-1 +: rdtc_pkg::GAIN_W];
	assign quot_ext = {1'b0, quot};

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			torque_command   <= neg_s2 ? $signed(-quot_ext) : $signed(quot_ext);
			zone_index       <= zone_s2;
			tracked_position <= pos_q;
		end
	end

endmodule

// File: hw/rtl/rotary_detent_torque_controller.sv
// Top level of the rotary detent torque controller.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  sample   | sample_valid/sample_stall | encoder_angle
//  result   | result_valid/result_stall | torque_command, zone_index, tracked_position
//  cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// Each sample passes through these steps in order: accept, scale multiply, gain multiply, output load.
// The two dependent multipliers in the datapath account for the two multiply steps.
// A finished result waits in the output register; the next sample is taken meanwhile.
// A stalled result holds the last step; the sample side stalls until it drains.
// Reset restores zone_count 10, torque_gain 175 and clears position and last angle.
module rotary_detent_torque_controller #(
	parameter int unsigned ANGLE_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic [ANGLE_BITS-1:0]                 encoder_angle,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [rdtc_pkg::TORQUE_W-1:0]  torque_command,
	output logic [rdtc_pkg::ZONE_W-1:0]           zone_index,
	output logic [ANGLE_BITS-1:0]                 tracked_position,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rdtc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rdtc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	rdtc_pkg::ctl_cmd_t cmd;

	// Configuration writes are always accepted; cfg_ready is tied high
	assign cfg_ready = 1'b1;

	rdtc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	rdtc_datapath #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.encoder_angle    (encoder_angle),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.torque_command   (torque_command),
		.zone_index       (zone_index),
		.tracked_position (tracked_position)
	);

endmodule

// File: hw/rtl/rdtc_checker.sv
// Port-level checker for the detent controller, bound to the top level.
`include "rotary_detent_torque_controller_defines.svh"

module rdtc_checker #(
	parameter int unsigned ANGLE_BITS = 14
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  sample_valid,
	input logic                                  sample_stall,
	input logic [ANGLE_BITS-1:0]                 encoder_angle,
	input logic                                  result_valid,
	input logic                                  result_stall,
	input logic signed [rdtc_pkg::TORQUE_W-1:0]  torque_command,
	input logic [rdtc_pkg::ZONE_W-1:0]           zone_index,
	input logic [ANGLE_BITS-1:0]                 tracked_position,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready
);

	localparam logic signed [rdtc_pkg::TORQUE_W-1:0] TORQUE_MIN_CODE =
		{1'b1, {(rdtc_pkg::TORQUE_W-1){1'b0}}};

	// A stalled result keeps its valid and payload
	`RDTC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(torque_command) && $stable(zone_index) && $stable(tracked_position))

	// A stalled sample keeps its valid and payload
	`RDTC_ASSERT_NEXT(a_sample_hold, clk, arst_n, sample_valid && sample_stall, sample_valid && $stable(encoder_angle))

	// After a sample transfer the block reports busy in the following cycle
	`RDTC_ASSERT_NEXT(a_busy_after_take, clk, arst_n, sample_valid && !sample_stall, sample_stall)

	// Torque magnitude is bounded by the 16-bit gain
	`RDTC_ASSERT_NOW(a_torque_bound, clk, arst_n, result_valid, torque_command != TORQUE_MIN_CODE)

	// Configuration writes are never held off
	`RDTC_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind rotary_detent_torque_controller rdtc_checker #(
	.ANGLE_BITS (ANGLE_BITS)
) u_rdtc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.sample_valid     (sample_valid),
	.sample_stall     (sample_stall),
	.encoder_angle    (encoder_angle),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.torque_command   (torque_command),
	.zone_index       (zone_index),
	.tracked_position (tracked_position),
	.cfg_valid        (cfg_valid),
	.cfg_ready        (cfg_ready)
);

// File: tb/rotary_detent_torque_controller_tb.sv
// Self-checking testbench for the rotary detent torque controller.

localparam int ANGLE_W = 14;
localparam longint unsigned HALF_TURN = 64'd1 << (ANGLE_W - 1);
localparam int unsigned MAX_ZONES = 64;

typedef struct packed {
	logic [rdtc_pkg::TORQUE_W-1:0] torque;
	logic [rdtc_pkg::ZONE_W-1:0]   zone;
	logic [ANGLE_W-1:0]            position;
} detent_result_t;

// Tracks the knob state and configuration, predicts one result per accepted sample
class detent_scoreboard;
	logic [rdtc_pkg::ZCNT_W-1:0] zone_cnt;
	logic [rdtc_pkg::GAIN_W-1:0] gain;
	logic [ANGLE_W-1:0]          prev_angle;
	logic [ANGLE_W-1:0]          position;
	detent_result_t              pending_detents[$];
	int                          errors;

	function new();
		zone_cnt   = rdtc_pkg::ZONE_COUNT_RST;
		gain       = rdtc_pkg::TORQUE_GAIN_RST;
		prev_angle = '0;
		position   = '0;
		errors     = 0;
	endfunction

	function void write_reg(logic [rdtc_pkg::CFG_IDX_W-1:0] idx,
			logic [rdtc_pkg::CFG_DATA_W-1:0] data);
		if (idx == rdtc_pkg::REG_ZONE_COUNT) begin
			zone_cnt = data[rdtc_pkg::ZCNT_W-1:0];
		end else if (idx == rdtc_pkg::REG_TORQUE_GAIN) begin
			gain = data[rdtc_pkg::GAIN_W-1:0];
		end
	endfunction

	// Mirrored position update, zone lookup and spring torque toward zone center
	function detent_result_t predict_detent(logic [ANGLE_W-1:0] angle);
		logic [ANGLE_W-1:0] pos;
		longint unsigned n, scaled, zone, center, mag;
		longint torque;
		detent_result_t r;
		pos = position + prev_angle - angle;
		prev_angle = angle;
		position = pos;
		n = zone_cnt;
		if (n == 0) begin
			n = 1;
		end else if (n > MAX_ZONES) begin
			n = MAX_ZONES;
		end
		scaled = 64'(pos) * n;
		zone = scaled >> ANGLE_W;
		center = (2 * zone + 1) * HALF_TURN;
		// truncate toward zero: divide the magnitude, then apply the sign
		if (scaled >= center) begin
			mag = scaled - center;
			torque = longint'((mag * gain) / HALF_TURN);
		end else begin
			mag = center - scaled;
			torque = -longint'((mag * gain) / HALF_TURN);
		end
		r.torque = torque[rdtc_pkg::TORQUE_W-1:0];
		r.zone = zone[rdtc_pkg::ZONE_W-1:0];
		r.position = pos;
		return r;
	endfunction

	function void note_sample(logic [ANGLE_W-1:0] angle);
		pending_detents.push_back(predict_detent(angle));
	endfunction

	function void check_result(logic [rdtc_pkg::TORQUE_W-1:0] torque,
			logic [rdtc_pkg::ZONE_W-1:0] zone, logic [ANGLE_W-1:0] pos);
		detent_result_t want;
		if (pending_detents.size() == 0) begin
			$error("result transfer with no expected result pending");
			errors++;
			return;
		end
		want = pending_detents.pop_front();
		if (torque !== want.torque) begin
			$error("torque_command: expected %0d, actual %0d",
				$signed(want.torque), $signed(torque));
			errors++;
		end
		if (zone !== want.zone) begin
			$error("zone_index: expected %0d, actual %0d", want.zone, zone);
			errors++;
		end
		if (pos !== want.position) begin
			$error("tracked_position: expected %0d, actual %0d", want.position, pos);
			errors++;
		end
	endfunction
endclass

module rotary_detent_torque_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 100;
	localparam int DRAIN_CYCLES = 20;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   sample_valid = 1'b0;
	logic                                   sample_stall;
	logic [ANGLE_W-1:0]                     encoder_angle = '0;
	logic                                   result_valid;
	logic                                   result_stall = 1'b0;
	logic signed [rdtc_pkg::TORQUE_W-1:0]   torque_command;
	logic [rdtc_pkg::ZONE_W-1:0]            zone_index;
	logic [ANGLE_W-1:0]                     tracked_position;
	logic                                   cfg_valid = 1'b0;
	logic                                   cfg_ready;
	logic [rdtc_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
	logic [rdtc_pkg::CFG_DATA_W-1:0]        cfg_data = '0;

	detent_scoreboard sb = new();

	// Angles waiting to be sent, plus the planned knob state used to aim at positions
	logic [ANGLE_W-1:0] angle_queue[$];
	logic [ANGLE_W-1:0] plan_last = '0;
	logic [ANGLE_W-1:0] plan_pos = '0;
	bit                 quiet = 1'b0;
	int                 cycle_count = 0;

	rotary_detent_torque_controller #(
		.ANGLE_BITS(ANGLE_W)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.encoder_angle   (encoder_angle),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.torque_command  (torque_command),
		.zone_index      (zone_index),
		.tracked_position(tracked_position),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #6 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rotary_detent_torque_controller_tb failed");
			$finish;
		end
	end

	function automatic bit idle_roll();
		return !quiet && ($urandom_range(99) < 29);
	endfunction

	function automatic void add_angle(logic [ANGLE_W-1:0] a);
		plan_pos = plan_pos + plan_last - a;
		plan_last = a;
		angle_queue.push_back(a);
	endfunction

	// Pick the angle that lands the tracked position on a chosen value
	function automatic void add_target(logic [ANGLE_W-1:0] pos);
		logic [ANGLE_W-1:0] a;
		a = plan_pos + plan_last - pos;
		add_angle(a);
	endfunction

	// Result side: check each transfer, then stall at random
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(torque_command, zone_index, tracked_position);
		end
		result_stall <= arst_n ? idle_roll() : 1'b0;
	end

	task automatic write_reg(input logic [rdtc_pkg::CFG_IDX_W-1:0] idx,
			input logic [rdtc_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Zone count in the low bits, random noise in the unused upper bits
	task automatic write_zones(input logic [rdtc_pkg::ZCNT_W-1:0] zones);
		logic [rdtc_pkg::CFG_DATA_W-1:0] data;
		data = rdtc_pkg::CFG_DATA_W'($urandom);
		data[rdtc_pkg::ZCNT_W-1:0] = zones;
		write_reg(rdtc_pkg::REG_ZONE_COUNT, data);
	endtask

	// Send every queued angle; one drive decision per clock edge unless a sample is held stalled
	task automatic send_samples();
		int count, sent, issued;
		count = angle_queue.size();
		sent = 0;
		issued = 0;
		while (sent < count) begin
			@(posedge clk);
			if (sample_valid && !sample_stall) begin
				sb.note_sample(encoder_angle);
				sent++;
			end
			if (!(sample_valid && sample_stall)) begin
				if (issued < count && !idle_roll()) begin
					sample_valid <= 1'b1;
					encoder_angle <= angle_queue.pop_front();
					issued++;
				end else begin
					sample_valid <= 1'b0;
					encoder_angle <= ANGLE_W'($urandom);
				end
			end
		end
	endtask

	// Phase boundary: all results back, then a further margin set by DRAIN_CYCLES
	task automatic drain();
		while (sb.pending_detents.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void add_random_angle();
		int mode, delta;
		mode = $urandom_range(99);
		if (mode < 60) begin
			// small knob motion either way
			delta = int'($urandom_range(600)) - 300;
			add_angle(ANGLE_W'(int'(plan_last) + delta));
		end else if (mode < 85) begin
			add_angle(ANGLE_W'($urandom));
		end else if (mode < 92) begin
			add_angle($urandom_range(1) ? '1 : '0);
		end else begin
			// land on or next to a zone center or edge
			add_target(ANGLE_W'(($urandom_range(127) << (ANGLE_W - 7))
				+ $urandom_range(2) - 1));
		end
	endfunction

	initial begin
		logic [rdtc_pkg::ZCNT_W-1:0] zones;
		logic [rdtc_pkg::GAIN_W-1:0] gain;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset configuration: turn extremes, wrap and a zone boundary
		add_angle('0);
		add_angle('1);
		add_angle('0);
		add_target('1);
		add_target('0);
		add_target(ANGLE_W'(HALF_TURN));
		add_angle('1);
		add_angle(ANGLE_W'(1));
		add_target(ANGLE_W'(1638));
		add_target(ANGLE_W'(1639));
		send_samples();
		drain();

		// Zone count zero acts as one zone; full gain, exact center gives zero torque
		write_zones('0);
		write_reg(rdtc_pkg::REG_TORQUE_GAIN, '1);
		add_target(ANGLE_W'(HALF_TURN));
		add_target('0);
		add_target('1);
		add_target(ANGLE_W'(HALF_TURN - 1));
		add_target(ANGLE_W'(HALF_TURN + 1));
		send_samples();
		drain();

		// Most zones, zero gain
		write_zones(rdtc_pkg::ZONES_MAX);
		write_reg(rdtc_pkg::REG_TORQUE_GAIN, '0);
		add_target('0);
		add_target('1);
		add_target(ANGLE_W'(256));
		add_target(ANGLE_W'(128));
		send_samples();
		drain();

		// Zone count above the maximum is clamped
		write_zones('1);
		write_reg(rdtc_pkg::REG_TORQUE_GAIN, '1);
		add_target(ANGLE_W'(128));
		add_target('0);
		add_target(ANGLE_W'(255));
		add_target('1);
		add_target(ANGLE_W'(129));
		send_samples();
		drain();

		// Random phases, each under its own setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			unique case (ph)
				0: begin
					zones = rdtc_pkg::ZONES_MIN;
					gain = '1;
				end
				1: begin
					zones = rdtc_pkg::ZONES_MAX;
					gain = rdtc_pkg::GAIN_W'($urandom);
				end
				2: begin
					zones = rdtc_pkg::ZCNT_W'($urandom_range(65, 127));
					gain = '0;
				end
				default: begin
					zones = rdtc_pkg::ZCNT_W'($urandom_range(0, 127));
					gain = rdtc_pkg::GAIN_W'($urandom);
				end
			endcase
			write_zones(zones);
			write_reg(rdtc_pkg::REG_TORQUE_GAIN, gain);
			quiet = (ph == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				add_random_angle();
			end
			send_samples();
			drain();
		end

		if (sb.errors == 0 && sb.pending_detents.size() == 0) begin
			$display("rotary_detent_torque_controller_tb passed");
		end else begin
			$display("rotary_detent_torque_controller_tb failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rdtc_pkg.sv
hw/rtl/rdtc_ctrl.sv
hw/rtl/rdtc_datapath.sv
hw/rtl/rotary_detent_torque_controller.sv
hw/rtl/rdtc_checker.sv
tb/rotary_detent_torque_controller_tb.sv
